// File: design/pav_pkg.sv
// Shared constants, codes and the node word layout for the versioned array.
// No dependencies; imported by persistent_array_versions.
package pav_pkg;

	localparam int MAX_LENGTH   = 1024;
	localparam int MAX_VERSIONS = 1024;
	localparam int POOL_NODES   = 16384;

	localparam int VAL_W   = 64;
	localparam int LEN_W   = $clog2(MAX_LENGTH) + 1;
	localparam int IVA_W   = $clog2(MAX_LENGTH);
	localparam int VER_W   = $clog2(MAX_VERSIONS);
	localparam int VCNT_W  = VER_W + 1;
	localparam int NADDR_W = $clog2(POOL_NODES);
	localparam int NCNT_W  = NADDR_W + 1;
	localparam int LVL_W   = $clog2(LEN_W + 1);
	localparam int STACK_DEPTH = LEN_W;
	localparam int SP_W    = $clog2(STACK_DEPTH + 1);
	localparam int ST_W    = 3;

	localparam logic [1:0] FN_LOAD   = 2'd0;
	localparam logic [1:0] FN_BUILD  = 2'd1;
	localparam logic [1:0] FN_UPDATE = 2'd2;
	localparam logic [1:0] FN_QUERY  = 2'd3;

	localparam logic [ST_W-1:0] ST_OK          = 3'd0;
	localparam logic [ST_W-1:0] ST_NOT_BUILT   = 3'd1;
	localparam logic [ST_W-1:0] ST_BAD_VERSION = 3'd2;
	localparam logic [ST_W-1:0] ST_BAD_INDEX   = 3'd3;
	localparam logic [ST_W-1:0] ST_NO_SPACE    = 3'd4;
	localparam logic [ST_W-1:0] ST_LOAD_AFTER  = 3'd5;

	typedef struct packed {
		logic [NADDR_W-1:0] left;
		logic [NADDR_W-1:0] right;
		logic [VAL_W-1:0]   leaf;
	} node_t;

	localparam int NODE_W = $bits(node_t);

endpackage

// File: design/pav_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pav_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/persistent_array_versions.sv
// Top level of the versioned array: path-copying segment tree in a node pool.
// Depends on pav_pkg and pav_ram.
//
// Channel  Direction  Handshake            Word
// -------  ---------  -------------------  ----------------------------------
// command  in         start && !busy       func, version, index, value
// result   out        done (one cycle)     read_value, new_version, status
// config   in         cfg_valid&&cfg_ready cfg_data (array_length)
//
// Load and every command rejected by the up-front checks give their result word
// on the cycle after acceptance. An update refused for lack of pool space is
// only found at the leaf, so it takes the full descent like a good one.
// An update or query first reads the version-root memory, then does one node
// memory read per level of the tree, which has ceil(log2(length)) + 1 levels.
// A build visits every tree node in preorder, with an extra initial-value
// memory read for each leaf. Reset clears only the control state; the
// memories are left as they are. The result side cannot stall.
module persistent_array_versions
	import pav_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        func,
	input  logic [VER_W-1:0]  version,
	input  logic [LEN_W-1:0]  index,
	input  logic signed [VAL_W-1:0] value,
	output logic              done,
	output logic signed [VAL_W-1:0] read_value,
	output logic [VER_W-1:0]  new_version,
	output logic [ST_W-1:0]   status,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [LEN_W-1:0]  cfg_data
);

	// Sequencer states.
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RWAIT = 3'd1;
	localparam logic [2:0] S_DESC  = 3'd2;
	localparam logic [2:0] S_BNODE = 3'd3;
	localparam logic [2:0] S_BLEAF = 3'd4;

	logic [2:0]          state_q;
	logic                built_q;
	logic [VCNT_W-1:0]   vu_q;
	logic [NCNT_W-1:0]   nodes_q;
	logic [LEN_W-1:0]    tree_len_q;
	logic [LEN_W-1:0]    arr_len_q;
	logic                is_upd_q;
	logic [LEN_W-1:0]    idx_q;
	logic [VAL_W-1:0]    val_q;
	logic [NADDR_W-1:0]  root_q;
	logic [LEN_W-1:0]    lo_q;
	logic [LEN_W-1:0]    hi_q;
	logic [LVL_W-1:0]    k_q;
	logic [NADDR_W-1:0]  me_q;
	logic [SP_W-1:0]     sp_q;
	logic [VAL_W-1:0]    rd_q;
	logic [VER_W-1:0]    nv_q;
	logic [ST_W-1:0]     st_q;
	logic                done_q;

	// Pending right subtrees during the build walk.
	logic [LEN_W-1:0]   stk_lo [STACK_DEPTH];
	logic [LEN_W-1:0]   stk_hi [STACK_DEPTH];
	logic [NADDR_W-1:0] stk_me [STACK_DEPTH];

	// Memory ports.
	logic               iv_we;
	logic [IVA_W-1:0]   iv_waddr;
	logic [VAL_W-1:0]   iv_wdata_w;
	logic [IVA_W-1:0]   iv_raddr;
	logic [VAL_W-1:0]   iv_rdata;
	logic               vr_we;
	logic [VER_W-1:0]   vr_waddr;
	logic [NADDR_W-1:0] vr_wdata;
	logic [NADDR_W-1:0] vr_rdata;
	logic               nd_we;
	logic [NADDR_W-1:0] nd_waddr;
	node_t              nd_wdata;
	logic [NADDR_W-1:0] nd_raddr;
	node_t              nd_rdata;

	logic accept;
	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done        = done_q;
	assign read_value  = rd_q;
	assign new_version = nv_q;
	assign status      = st_q;

	// Midpoint of the range under work, shared by the build and the descent.
	logic [LEN_W-1:0] mid;
	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	// Build length, clamped into the legal range, and the node count it needs.
	logic [LEN_W-1:0] blen;
	logic [LEN_W:0]   bnodes;
	always_comb begin
		blen = arr_len_q;
		if (arr_len_q == '0) begin
			blen = LEN_W'(1);
		end else if (int'(arr_len_q) > MAX_LENGTH) begin
			blen = LEN_W'(MAX_LENGTH);
		end
		bnodes = {blen, 1'b0} - (LEN_W+1)'(1);
	end

	// In preorder the left child follows its parent; the right child comes
	// after the whole left subtree, which holds 2*(mid-lo+1)-1 nodes.
	logic [NADDR_W-1:0] b_left;
	logic [NADDR_W-1:0] b_right;
	assign b_left  = me_q + NADDR_W'(1);
	assign b_right = me_q + NADDR_W'({(mid - lo_q + LEN_W'(1)), 1'b0});

	// Descent: the copy at level k lands at nodes_used + k.
	logic [NCNT_W:0]    base;
	logic [NCNT_W:0]    base_n;
	logic               in_pool;
	logic               go_left;
	logic               at_leaf;
	logic [NADDR_W-1:0] child;
	assign base    = {1'b0, nodes_q} + (NCNT_W+1)'(k_q);
	assign base_n  = base + (NCNT_W+1)'(1);
	assign in_pool = (int'(base) < POOL_NODES);
	assign go_left = (idx_q <= mid);
	assign at_leaf = (lo_q == hi_q);
	assign child   = go_left ? nd_rdata.left : nd_rdata.right;

	// Command checks for update and query.
	logic [ST_W-1:0] uq_st;
	always_comb begin
		uq_st = ST_OK;
		if (!built_q) begin
			uq_st = ST_NOT_BUILT;
		end else if ({1'b0, version} >= vu_q) begin
			uq_st = ST_BAD_VERSION;
		end else if (index == '0 || index > tree_len_q) begin
			uq_st = ST_BAD_INDEX;
		end else if (int'(vu_q) >= MAX_VERSIONS) begin
			uq_st = ST_NO_SPACE;
		end
	end

	logic ld_ok;
	assign ld_ok = !built_q && index != '0 && int'(index) <= MAX_LENGTH;

	// Memory port steering. The new root of an update is the level-zero
	// copy, which sits at the first free node.
	always_comb begin
		iv_we    = accept && func == FN_LOAD && ld_ok;
		iv_waddr = IVA_W'(index - LEN_W'(1));
		iv_raddr = IVA_W'(lo_q - LEN_W'(1));

		vr_we    = 1'b0;
		vr_waddr = vu_q[VER_W-1:0];
		vr_wdata = is_upd_q ? nodes_q[NADDR_W-1:0] : root_q;

		nd_we    = 1'b0;
		nd_waddr = me_q;
		nd_wdata = '0;
		nd_raddr = child;

		case (state_q)
			S_IDLE: begin
				if (accept && func == FN_BUILD && int'(bnodes) <= POOL_NODES) begin
					vr_we    = 1'b1;
					vr_waddr = '0;
					vr_wdata = '0;
				end
			end
			S_RWAIT: begin
				nd_raddr = vr_rdata;
			end
			S_DESC: begin
				nd_waddr = base[NADDR_W-1:0];
				nd_wdata = nd_rdata;
				if (at_leaf) begin
					nd_wdata.leaf = val_q;
					vr_we = !is_upd_q || int'(base_n) <= POOL_NODES;
				end else if (go_left) begin
					nd_wdata.left = base_n[NADDR_W-1:0];
				end else begin
					nd_wdata.right = base_n[NADDR_W-1:0];
				end
				nd_we = is_upd_q && in_pool;
			end
			S_BNODE: begin
				if (!at_leaf) begin
					nd_we          = 1'b1;
					nd_wdata.left  = b_left;
					nd_wdata.right = b_right;
				end
			end
			S_BLEAF: begin
				nd_we         = 1'b1;
				nd_wdata.leaf = iv_rdata;
			end
			default: begin
			end
		endcase
	end

	assign iv_wdata_w = value;

	pav_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LENGTH)) u_iv_ram (
		.clk   (clk),
		.we    (iv_we),
		.waddr (iv_waddr),
		.wdata (iv_wdata_w),
		.raddr (iv_raddr),
		.rdata (iv_rdata)
	);

	pav_ram #(.WIDTH(NADDR_W), .DEPTH(MAX_VERSIONS)) u_vr_ram (
		.clk   (clk),
		.we    (vr_we),
		.waddr (vr_waddr),
		.wdata (vr_wdata),
		.raddr (version),
		.rdata (vr_rdata)
	);

	pav_ram #(.WIDTH(NODE_W), .DEPTH(POOL_NODES)) u_node_ram (
		.clk   (clk),
		.we    (nd_we),
		.waddr (nd_waddr),
		.wdata (nd_wdata),
		.raddr (nd_raddr),
		.rdata (nd_rdata)
	);

	// Build stack: push the right half when an internal node is written.
	always_ff @(posedge clk) begin
		if (state_q == S_BNODE && !at_leaf) begin
			stk_lo[sp_q] <= mid + LEN_W'(1);
			stk_hi[sp_q] <= hi_q;
			stk_me[sp_q] <= b_right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			built_q    <= 1'b0;
			vu_q       <= '0;
			nodes_q    <= '0;
			tree_len_q <= '0;
			arr_len_q  <= LEN_W'(MAX_LENGTH);
			sp_q       <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				arr_len_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q    <= index;
						val_q    <= value;
						is_upd_q <= (func == FN_UPDATE);
						rd_q     <= '0;
						nv_q     <= '0;
						k_q      <= '0;
						lo_q     <= LEN_W'(1);
						hi_q     <= tree_len_q;
						case (func)
							FN_LOAD: begin
								done_q <= 1'b1;
								if (built_q) begin
									st_q <= ST_LOAD_AFTER;
								end else if (!ld_ok) begin
									st_q <= ST_BAD_INDEX;
								end else begin
									st_q <= ST_OK;
								end
							end
							FN_BUILD: begin
								built_q <= 1'b0;
								vu_q    <= '0;
								nodes_q <= '0;
								if (int'(bnodes) > POOL_NODES) begin
									st_q   <= ST_NO_SPACE;
									done_q <= 1'b1;
								end else begin
									st_q       <= ST_OK;
									tree_len_q <= blen;
									nodes_q    <= NCNT_W'(bnodes);
									vu_q       <= VCNT_W'(1);
									lo_q       <= LEN_W'(1);
									hi_q       <= blen;
									me_q       <= '0;
									sp_q       <= '0;
									state_q    <= S_BNODE;
								end
							end
							default: begin
								st_q <= uq_st;
								if (uq_st == ST_OK) begin
									state_q <= S_RWAIT;
								end else begin
									done_q <= 1'b1;
								end
							end
						endcase
					end
				end
				S_RWAIT: begin
					root_q  <= vr_rdata;
					state_q <= S_DESC;
				end
				S_DESC: begin
					if (at_leaf) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						if (is_upd_q && int'(base_n) > POOL_NODES) begin
							st_q <= ST_NO_SPACE;
						end else begin
							nv_q <= vu_q[VER_W-1:0];
							vu_q <= vu_q + VCNT_W'(1);
							if (is_upd_q) begin
								nodes_q <= base_n[NCNT_W-1:0];
							end else begin
								rd_q <= nd_rdata.leaf;
							end
						end
					end else begin
						k_q <= k_q + LVL_W'(1);
						if (go_left) begin
							hi_q <= mid;
						end else begin
							lo_q <= mid + LEN_W'(1);
						end
					end
				end
				S_BNODE: begin
					if (at_leaf) begin
						state_q <= S_BLEAF;
					end else begin
						sp_q <= sp_q + SP_W'(1);
						hi_q <= mid;
						me_q <= b_left;
					end
				end
				S_BLEAF: begin
					if (sp_q == '0) begin
						built_q <= 1'b1;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						lo_q    <= stk_lo[sp_q - SP_W'(1)];
						hi_q    <= stk_hi[sp_q - SP_W'(1)];
						me_q    <= stk_me[sp_q - SP_W'(1)];
						sp_q    <= sp_q - SP_W'(1);
						state_q <= S_BNODE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// A result word only appears while the block is idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result word while busy");

	// The build stack never grows past its depth.
	a_stack: assert property (@(posedge clk) disable iff (!arst_n)
		int'(sp_q) <= STACK_DEPTH) else $error("build stack overflow");

	// Allocation counters stay inside the pool and version table.
	a_pool: assert property (@(posedge clk) disable iff (!arst_n)
		int'(nodes_q) <= POOL_NODES && int'(vu_q) <= MAX_VERSIONS)
		else $error("allocation counter overflow");

	// A successful query adds exactly one version; the check covers queries only.
	a_vu_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DESC && at_leaf && st_q == ST_OK && !is_upd_q)
		|=> vu_q == $past(vu_q) + VCNT_W'(1)) else $error("version count slip");
`endif

endmodule
